// File: hdl/pfsn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsn_pkg
// Shared types, constants and the fixed-point saturation helper of the PI-feedback neuron core.
// ----------------------------------------------------------------------------
package pfsn_pkg;

  localparam int NEURONS  = 1024;
  localparam int IDX_W    = $clog2(NEURONS);
  localparam int Q_W      = 32;
  localparam int TS_W     = 16;
  localparam int ACC_W    = 40;
  localparam int CFG_IDX_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEAK_POT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK_DEN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_OFS   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_POT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 4'd7;

  localparam logic [TS_W-1:0] TIME_STEP_RST = 16'd66;

  // result status codes
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_FIRED   = 2'd2;
  localparam logic [1:0] ST_SKIPPED = 2'd3;

  // update sequencer
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd18;

  typedef logic signed [Q_W-1:0] q_t;

  typedef struct packed {
    logic [TS_W-1:0] last;
    q_t              p2;
    q_t              p1;
    q_t              ig;
    q_t              u2;
    q_t              u1;
    q_t              v;
  } entry_t;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_DEC  = 5'b00100,
    S_UPD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  // saturate a wide signed value to Q16.16 range
  function automatic q_t sat_q(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (x > hi)      sat_q = q_t'(hi[Q_W-1:0]);
    else if (x < lo) sat_q = q_t'(lo[Q_W-1:0]);
    else             sat_q = q_t'(x[Q_W-1:0]);
  endfunction

endpackage

// File: hdl/pi_feedback_spiking_neuron_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_feedback_spiking_neuron_core
// Two-compartment PI-feedback neuron table with one shared multiplier.
// ----------------------------------------------------------------------------
// Flow: an access without update passes S_DEC and S_OUT before its result is
// registered; a full update also runs the 19 sequencer steps of S_UPD through
// the one multiplier. One word is handled at a time: the next word is taken once
// the result is loaded into the output register, which waits while a held result
// is not yet taken. Reset: synchronous; a clearing pass zeroes all 1024 table
// entries, during which no word is accepted (configuration writes still are).
module pi_feedback_spiking_neuron_core import pfsn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // neuron[9:0] timestep[25:10] current[57:26] noise[89:58]
  input  logic [1:0]  in_tuser,   // has_current[0] compartment[1]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // potential[31:0]
  output logic [1:0]  out_tuser,  // status[1:0]
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state_r, state_nxt;

  // configuration registers
  q_t lp_r, ld_r, kp_r, ki_r, eo_r, thr_r, rp_r;
  logic [TS_W-1:0] dt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r <= '0; ld_r <= '0; kp_r <= '0; ki_r <= '0;
      eo_r <= '0; thr_r <= '0; rp_r <= '0; dt_r <= TIME_STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEAK_POT:  lp_r  <= cfg_data;
        REG_LEAK_DEN:  ld_r  <= cfg_data;
        REG_GAIN_P:    kp_r  <= cfg_data;
        REG_GAIN_I:    ki_r  <= cfg_data;
        REG_ERR_OFS:   eo_r  <= cfg_data;
        REG_THRESHOLD: thr_r <= cfg_data;
        REG_RESET_POT: rp_r  <= cfg_data;
        REG_TIME_STEP: dt_r  <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // captured input word
  logic [IDX_W-1:0] nrn_r;
  logic [TS_W-1:0]  ts_r;
  logic             has_r, cmp_r;
  q_t               cur_r, noise_r;
  logic             in_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      nrn_r   <= in_tdata[IDX_W-1:0];
      ts_r    <= in_tdata[25:10];
      cur_r   <= in_tdata[57:26];
      noise_r <= in_tdata[89:58];
      has_r   <= in_tuser[0];
      cmp_r   <= in_tuser[1];
    end
  end

  // neuron table
  entry_t           mem_q [NEURONS];
  entry_t           rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  assign rd_addr = (state_r == S_IDLE) ? in_tdata[IDX_W-1:0] : nrn_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  // clearing pass counter
  logic [IDX_W:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n)                 clr_r <= '0;
    else if (state_r == S_CLR)  clr_r <= clr_r + 1'b1;
  end

  // step decode
  logic [TS_W-1:0] dstep;
  logic            do_upd, do_skip;

  assign dstep   = ts_r - rd_q.last;
  assign do_upd  = (dstep == 16'd1);
  assign do_skip = !dstep[TS_W-1] && (dstep > 16'd1);

  // update sequencer registers
  logic [STEP_W-1:0] step_r;
  entry_t            e_r;
  q_t                k_r, t_r, u1_r, u2_r, err_r, ig_r;
  logic signed [ACC_W-1:0] acc_r;
  q_t                op_a, op_b, mq;

  pfsn_mulq u_mulq (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .mq   (mq)
  );

  q_t dt_q;
  assign dt_q = q_t'({16'd0, dt_r});

  // multiplier operand per step
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_r)
      5'd0:  begin op_a = ld_r; op_b = dt_q;  end
      5'd2:  begin op_a = k_r;  op_b = e_r.u1; end
      5'd3:  begin op_a = k_r;  op_b = e_r.u2; end
      5'd4:  begin op_a = ld_r; op_b = e_r.p2; end
      5'd5:  begin op_a = lp_r; op_b = dt_q;  end
      5'd7:  begin op_a = dt_q; op_b = err_r; end
      5'd8:  begin op_a = t_r;  op_b = e_r.v; end
      5'd9:  begin op_a = dt_q; op_b = kp_r;  end
      5'd11: begin op_a = t_r;  op_b = err_r; end
      5'd12: begin op_a = dt_q; op_b = ki_r;  end
      5'd14: begin op_a = t_r;  op_b = ig_r;  end
      5'd15: begin op_a = dt_q; op_b = u2_r;  end
      default: ;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (state_r == S_DEC) begin
      e_r    <= rd_q;
      step_r <= '0;
    end else if (state_r == S_UPD) begin
      step_r <= step_r + 1'b1;
      unique case (step_r)
        5'd1:  k_r  <= mq;
        5'd3:  u1_r <= sat_q(64'(e_r.u1) - 64'(mq) + 64'(e_r.p1));
        5'd4:  acc_r <= ACC_W'(e_r.u2) - ACC_W'(mq);
        5'd5: begin
          u2_r  <= sat_q(64'(acc_r) + 64'(mq));
          err_r <= sat_q(64'(u1_r) + 64'(eo_r));
        end
        5'd6:  t_r  <= mq;
        5'd8:  ig_r <= sat_q(64'(e_r.ig) + 64'(mq));
        5'd9:  acc_r <= ACC_W'(e_r.v) - ACC_W'(mq);
        5'd10: t_r  <= mq;
        5'd12: acc_r <= acc_r + ACC_W'(mq);
        5'd13: t_r  <= mq;
        5'd15: acc_r <= acc_r + ACC_W'(mq);
        5'd16: acc_r <= acc_r + ACC_W'(mq);
        5'd17: acc_r <= acc_r + ACC_W'(noise_r) - ACC_W'(e_r.p2);
        default: ;
      endcase
    end
  end

  // final potential and fire test
  q_t   v_sat, v_fin;
  logic fired;

  assign v_sat = sat_q(64'(acc_r));
  assign fired = v_sat > thr_r;
  assign v_fin = fired ? rp_r : v_sat;

  // pending sums with the current added
  q_t p1_acc, p2_acc;
  assign p1_acc = (has_r && !cmp_r) ? sat_q(64'(rd_q.p1) + 64'(cur_r)) : rd_q.p1;
  assign p2_acc = (has_r &&  cmp_r) ? sat_q(64'(rd_q.p2) + 64'(cur_r)) : rd_q.p2;

  // table write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = nrn_r;
    wr_data = rd_q;
    priority if (state_r == S_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r[IDX_W-1:0];
      wr_data = '0;
    end else if (state_r == S_DEC && !do_upd && !do_skip) begin
      wr_en      = 1'b1;
      wr_data.p1 = p1_acc;
      wr_data.p2 = p2_acc;
    end else if (state_r == S_UPD && step_r == LAST_STEP) begin
      wr_en        = 1'b1;
      wr_data.v    = v_fin;
      wr_data.u1   = u1_r;
      wr_data.u2   = u2_r;
      wr_data.ig   = ig_r;
      wr_data.p1   = (has_r && !cmp_r) ? cur_r : '0;
      wr_data.p2   = (has_r &&  cmp_r) ? cur_r : '0;
      wr_data.last = ts_r;
    end else begin
      wr_en = 1'b0;
    end
  end

  // held result
  logic [1:0] res_stat_r;
  q_t         res_pot_r;

  always_ff @(posedge clk) begin
    if (state_r == S_DEC) begin
      res_stat_r <= do_skip ? ST_SKIPPED : ST_IDLE;
      res_pot_r  <= rd_q.v;
    end else if (state_r == S_UPD && step_r == LAST_STEP) begin
      res_stat_r <= fired ? ST_FIRED : ST_UPDATED;
      res_pot_r  <= v_fin;
    end
  end

  // output register
  logic       out_vld_r;
  logic [1:0] out_stat_r;
  q_t         out_pot_r;
  logic       out_load;

  assign out_load = (state_r == S_OUT) && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n)                     out_vld_r <= 1'b0;
    else if (out_load)              out_vld_r <= 1'b1;
    else if (out_tready)            out_vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_stat_r <= res_stat_r;
      out_pot_r  <= res_pot_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_pot_r;
  assign out_tuser  = out_stat_r;

  // control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_r == (IDX_W+1)'(NEURONS - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_fire) state_nxt = S_DEC;
      S_DEC:  state_nxt = do_upd ? S_UPD : S_OUT;
      S_UPD:  if (step_r == LAST_STEP) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

`ifndef ASSERT_OFF
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_tready)
    else $error("word accepted during clearing pass");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_DEC))
    else $error("accepted word not decoded next cycle");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (step_r <= LAST_STEP))
    else $error("sequencer step out of range");

  a_fire_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && res_stat_r == ST_FIRED) |-> (res_pot_r == rp_r))
    else $error("fired neuron not loaded with reset potential");
`endif

endmodule

// File: hdl/pfsn_mulq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsn_mulq
// Shared Q16.16 multiplier: registered product, then round half up and saturate.
// ----------------------------------------------------------------------------
module pfsn_mulq import pfsn_pkg::*; (
  input  logic clk,
  input  q_t   op_a,
  input  q_t   op_b,
  output q_t   mq      // result of the operands given in the previous cycle
);

  logic signed [63:0] prod_r;
  logic signed [63:0] rnd;
  logic signed [63:0] shf;

  // product register
  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

  // round half up, floor shift, saturate
  assign rnd = prod_r + 64'sd32768;
  assign shf = rnd >>> 16;
  assign mq  = sat_q(shf);

endmodule
